### sv/odometry_pose_integrator_assert.svh
// ----------------------------------------------------------------------------
// Odometry pose integrator assertion macros
// Shared concurrent assertion forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ODOMETRY_POSE_INTEGRATOR_ASSERT_SVH
`define ODOMETRY_POSE_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define OPI_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define OPI_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### sv/opi_pkg.sv
// ----------------------------------------------------------------------------
// Odometry pose integrator package
// Sizes, constants, cell word type and arctangent table.
// ----------------------------------------------------------------------------
package opi_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ANGLE_BITS   = 32;

    localparam int CW = 46;  // CORDIC coordinate width, 2^-36 m
    localparam int ZW = 34;  // residual angle width
    localparam int IW = 33;  // heading increment width

    localparam logic [31:0] ANGLE_MASK = 32'(64'hFFFF_FFFF << (32 - ANGLE_BITS));
    localparam logic [30:0] GAIN_COMP  = 31'd652032874;

    localparam logic [1:0] REG_LINEAR_GAIN    = 2'd0;
    localparam logic [1:0] REG_GYRO_SCALE     = 2'd1;
    localparam logic [1:0] REG_RATE_THRESHOLD = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_cell;

    function automatic logic [31:0] atan_val(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### sv/odometry_pose_integrator.sv
// ----------------------------------------------------------------------------
// Odometry pose integrator
// Dead-reckoning pose update: scaled step rotated by a CORDIC cell chain,
// saturating x/y accumulation, wrapping heading.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  input    | i_valid / o_ready      | i_linear_step, i_gyro_rate
//  output   | o_valid / i_ready      | o_pos_x, o_pos_y, o_heading
//  config   | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One word in flight: 4 front stages + CORDIC_STEPS cells + 1 output register.
// The next word is accepted the cycle after the result is loaded into the
// output register, so a new word waits until the last one is through.
// The result sits in an output register; a stalled result holds the next
// input off. Reset clears pose and restores register defaults.
// ----------------------------------------------------------------------------
`include "odometry_pose_integrator_assert.svh"

module odometry_pose_integrator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [23:0] i_linear_step,
    input  logic signed [15:0] i_gyro_rate,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [31:0]        o_heading,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);

    localparam int N = opi_pkg::CORDIC_STEPS;

    logic [15:0]        r_gain;
    logic [23:0]        r_scale;
    logic [30:0]        r_thr;
    logic signed [31:0] r_x, r_y;
    logic [31:0]        r_hd;
    logic               r_busy, r_pend, r_oval;
    logic signed [31:0] r_ox, r_oy;
    logic [31:0]        r_oh;

    opi_pkg::t_cell     w_c [N+1];
    logic [31:0]        w_inc;
    logic               w_start, w_done, w_load;
    logic [N-1:0]       w_vmap;
    logic signed [25:0] w_rx, w_ry;
    logic signed [33:0] w_sx, w_sy;
    logic signed [31:0] n_x, n_y;

    assign o_ready = !r_busy && !r_pend;
    assign w_start = i_valid && o_ready;

    opi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_linear_step(i_linear_step),
        .i_gyro_rate  (i_gyro_rate),
        .i_gain       (r_gain),
        .i_scale      (r_scale),
        .i_thr        (r_thr),
        .i_heading    (r_hd),
        .o_c          (w_c[0]),
        .o_inc        (w_inc)
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        opi_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(5'(g)),
            .i_d    (w_c[g]),
            .o_q    (w_c[g+1])
        );
        assign w_vmap[g] = w_c[g+1].valid;
    end

    assign w_done = w_c[N].valid;

    always_comb begin
        w_rx = 26'((w_c[N].cx + 46'sd524288) >>> 20);
        w_ry = 26'((w_c[N].cy + 46'sd524288) >>> 20);
        if (w_c[N].flip) begin
            w_rx = -w_rx;
            w_ry = -w_ry;
        end
        w_sx = 34'(r_x) + 34'(w_rx);
        w_sy = 34'(r_y) + 34'(w_ry);
        if (w_sx > 34'sd2147483647)       n_x = 32'sh7FFFFFFF;
        else if (w_sx < -34'sd2147483648) n_x = 32'sh80000000;
        else                              n_x = 32'(w_sx);
        if (w_sy > 34'sd2147483647)       n_y = 32'sh7FFFFFFF;
        else if (w_sy < -34'sd2147483648) n_y = 32'sh80000000;
        else                              n_y = 32'(w_sy);
    end

    // pose in accumulators goes out once the output register is free
    assign w_load = (r_pend || w_done) && (!r_oval || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= 16'd17203;
            r_scale <= 24'd116507;
            r_thr   <= 31'd68357;
            r_x     <= '0;
            r_y     <= '0;
            r_hd    <= '0;
            r_busy  <= 1'b0;
            r_pend  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    opi_pkg::REG_LINEAR_GAIN:    r_gain  <= i_cfg_data[15:0];
                    opi_pkg::REG_GYRO_SCALE:     r_scale <= i_cfg_data[23:0];
                    opi_pkg::REG_RATE_THRESHOLD: r_thr   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_start) begin
                r_busy <= 1'b1;
            end
            if (w_done) begin
                r_busy <= 1'b0;
                r_x    <= n_x;
                r_y    <= n_y;
                r_hd   <= r_hd + w_inc;
            end
            r_pend <= (r_pend || w_done) && !w_load;
            if (w_load) begin
                r_oval <= 1'b1;
            end else if (i_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ox <= w_done ? n_x : r_x;
            r_oy <= w_done ? n_y : r_y;
            r_oh <= w_done ? r_hd + w_inc : r_hd;
        end
    end

    assign o_valid   = r_oval;
    assign o_pos_x   = r_ox;
    assign o_pos_y   = r_oy;
    assign o_heading = r_oh;

    `OPI_ASSERT_IMPLY(a_one_in_chain, i_clk, i_rst_n, 1'b1, $onehot0(w_vmap))
    `OPI_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, w_start, r_busy && !o_ready)
    `OPI_ASSERT_IMPLY(a_pend_held, i_clk, i_rst_n, r_pend, r_oval && !r_busy)
    `OPI_ASSERT_IMPLY(a_done_busy, i_clk, i_rst_n, w_done, r_busy && !r_pend)

endmodule

### sv/opi_front.sv
// ----------------------------------------------------------------------------
// Odometry pose integrator front end
// Scales step and gyro word, thresholds the increment, forms the CORDIC
// start word. Four registered stages.
// ----------------------------------------------------------------------------
module opi_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [23:0]     i_linear_step,
    input  logic signed [15:0]     i_gyro_rate,
    input  logic [15:0]            i_gain,
    input  logic [23:0]            i_scale,
    input  logic [30:0]            i_thr,
    input  logic [31:0]            i_heading,
    output opi_pkg::t_cell         o_c,
    output logic [31:0]            o_inc
);

    logic                       r_v1, r_v2, r_v3;
    logic signed [40:0]         r_ps, r_pr;
    logic signed [26:0]         r_s;
    logic signed [opi_pkg::ZW-1:0] r_z2, r_z3;
    logic                       r_f2, r_f3;
    logic signed [57:0]         r_m;
    opi_pkg::t_cell             r_c;
    logic [31:0]                r_inc;

    logic signed [26:0]         n_s;
    logic signed [opi_pkg::IW-1:0] n_inc, w_mag;
    logic [31:0]                w_phi;
    logic                       w_flip;

    always_comb begin
        n_s   = 27'((r_ps + 41'sd8192) >>> 14);
        n_inc = 33'((r_pr + 41'sd128) >>> 8);
        w_mag = n_inc[opi_pkg::IW-1] ? -n_inc : n_inc;
        if (w_mag <= $signed({2'b00, i_thr})) begin
            n_inc = '0;
        end
        w_phi  = (i_heading + 32'(n_inc >>> 1)) & opi_pkg::ANGLE_MASK;
        w_flip = w_phi[31] ^ w_phi[30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end else begin
            r_c.valid <= r_v3;
        end
        if (i_start) begin
            r_ps <= 41'(i_linear_step * $signed({1'b0, i_gain}));
            r_pr <= 41'(i_gyro_rate * $signed({1'b0, i_scale}));
        end
        if (r_v1) begin
            r_s   <= n_s;
            r_inc <= 32'(n_inc);
            r_z2  <= {{(opi_pkg::ZW-32){w_phi[31] ^ w_flip}}, w_phi[31] ^ w_flip, w_phi[30:0]};
            r_f2  <= w_flip;
        end
        if (r_v2) begin
            r_m  <= 58'(r_s * $signed({1'b0, opi_pkg::GAIN_COMP}));
            r_z3 <= r_z2;
            r_f3 <= r_f2;
        end
        if (r_v3) begin
            r_c.cx   <= opi_pkg::CW'((r_m + 58'sd8192) >>> 14);
            r_c.cy   <= '0;
            r_c.z    <= r_z3;
            r_c.flip <= r_f3;
        end
    end

    assign o_c   = r_c;
    assign o_inc = r_inc;

endmodule

### sv/opi_cordic_cell.sv
// ----------------------------------------------------------------------------
// Odometry pose integrator CORDIC cell
// One rotation micro-step; passes its word to the next cell each cycle.
// ----------------------------------------------------------------------------
module opi_cordic_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [4:0]     i_shift,
    input  opi_pkg::t_cell i_d,
    output opi_pkg::t_cell o_q
);

    opi_pkg::t_cell                r_q;
    logic signed [opi_pkg::CW-1:0] w_dx, w_dy;
    logic signed [opi_pkg::ZW-1:0] w_at;

    always_comb begin
        w_dx = i_d.cx >>> i_shift;
        w_dy = i_d.cy >>> i_shift;
        w_at = $signed({2'b00, opi_pkg::atan_val(i_shift)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q.valid <= i_d.valid;
        end
        r_q.flip <= i_d.flip;
        if (!i_d.z[opi_pkg::ZW-1]) begin
            r_q.cx <= i_d.cx - w_dy;
            r_q.cy <= i_d.cy + w_dx;
            r_q.z  <= i_d.z - w_at;
        end else begin
            r_q.cx <= i_d.cx + w_dy;
            r_q.cy <= i_d.cy - w_dx;
            r_q.z  <= i_d.z + w_at;
        end
    end

    assign o_q = r_q;

endmodule

### tb/sv/odometry_pose_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Odometry pose checker
// Watches the input, output and register write ports of the pose integrator,
// predicts each pose from its own copy of the registers and pose state, and
// compares every output word field by field, in order.
// ----------------------------------------------------------------------------
module odometry_pose_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_o_ready,
    input  logic signed [23:0] i_linear_step,
    input  logic signed [15:0] i_gyro_rate,
    input  logic               i_o_valid,
    input  logic               i_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [31:0]        i_heading,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] hd;
    } t_pose;

    t_pose       pose_q[$];
    logic [15:0] gain_r;
    logic [23:0] scale_r;
    logic [30:0] thr_r;
    logic [31:0] x_r, y_r, hd_r;

    function automatic longint rshift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift_round(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] sat_acc(logic [31:0] acc, longint d);
        longint sum;
        sum = longint'($signed(acc)) + d;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    task automatic advance_pose(logic signed [23:0] stp, logic signed [15:0] rate);
        longint s, inc, mag, z, cx, cy, dx, dy;
        logic [31:0] phi;
        logic        flip;
        s   = rshift_round(longint'(stp) * longint'(gain_r), 14);
        inc = rshift_round(longint'(rate) * longint'(scale_r), 8);
        mag = inc < 0 ? -inc : inc;
        if (mag <= longint'(thr_r)) inc = 0;
        phi  = (hd_r + 32'(rshift_floor(inc, 1))) & opi_pkg::ANGLE_MASK;
        flip = (phi + 32'h4000_0000) >> 31;
        if (flip) phi = phi - 32'h8000_0000;
        z  = longint'($signed(phi));
        cx = rshift_round(s * 64'sd652032874, 14);
        cy = 0;
        for (int i = 0; i < opi_pkg::CORDIC_STEPS; i++) begin
            dx = rshift_floor(cx, i);
            dy = rshift_floor(cy, i);
            if (z >= 0) begin
                cx -= dy; cy += dx; z -= longint'(opi_pkg::atan_val(5'(i)));
            end else begin
                cx += dy; cy -= dx; z += longint'(opi_pkg::atan_val(5'(i)));
            end
        end
        cx = rshift_round(cx, 20);
        cy = rshift_round(cy, 20);
        if (flip) begin
            cx = -cx; cy = -cy;
        end
        x_r  = sat_acc(x_r, cx);
        y_r  = sat_acc(y_r, cy);
        hd_r = hd_r + 32'(inc);
        pose_q.push_back('{x_r, y_r, hd_r});
    endtask

    assign o_pending = pose_q.size();

    always @(posedge i_clk) begin
        t_pose e;
        if (!i_rst_n) begin
            gain_r  <= 16'd17203;
            scale_r <= 24'd116507;
            thr_r   <= 31'd68357;
            x_r = 0; y_r = 0; hd_r = 0;
            pose_q.delete();
            o_errors <= 0;
        end else begin
            if (i_o_valid && i_ready) begin
                if (pose_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected pose word %h %h %h",
                        i_pos_x, i_pos_y, i_heading);
                end else begin
                    e = pose_q.pop_front();
                    if (e.x !== i_pos_x || e.y !== i_pos_y || e.hd !== i_heading) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("pose mismatch: exp x=%h y=%h h=%h got x=%h y=%h h=%h",
                                e.x, e.y, e.hd, i_pos_x, i_pos_y, i_heading);
                    end
                end
            end
            if (i_valid && i_o_ready) advance_pose(i_linear_step, i_gyro_rate);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    opi_pkg::REG_LINEAR_GAIN:    gain_r  <= i_cfg_data[15:0];
                    opi_pkg::REG_GYRO_SCALE:     scale_r <= i_cfg_data[23:0];
                    opi_pkg::REG_RATE_THRESHOLD: thr_r   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/odometry_pose_integrator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Odometry pose integrator testbench
// Directed extremes then random step/gyro words under several register
// settings, with random gaps on both channels; the checker predicts poses.
// ----------------------------------------------------------------------------
module odometry_pose_integrator_tb;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [23:0] step = 0;
    logic signed [15:0] rate = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [31:0] pos_x, pos_y;
    logic [31:0]        hd;
    logic               cfg_we = 0;
    logic [1:0]         cfg_idx = 0;
    logic [30:0]        cfg_data = 0;
    int                 errors, pending;
    int                 cycles = 0;

    odometry_pose_integrator DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_linear_step(step), .i_gyro_rate(rate), .o_valid(out_valid),
        .i_ready(out_ready), .o_pos_x(pos_x), .o_pos_y(pos_y), .o_heading(hd),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    odometry_pose_checker checker_u (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_o_ready(in_ready),
        .i_linear_step(step), .i_gyro_rate(rate), .i_o_valid(out_valid),
        .i_ready(out_ready), .i_pos_x(pos_x), .i_pos_y(pos_y), .i_heading(hd),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output stall: random stretches of not ready, mostly short
    initial begin
        int g;
        @(posedge clk);
        forever begin
            g = gap_len();
            if (g != 0) begin
                out_ready <= 0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

    task automatic send_word(logic signed [23:0] s, logic signed [15:0] r);
        int g;
        g = gap_len();
        repeat (g) @(posedge clk);
        in_valid <= 1;
        step <= s;
        rate <= r;
        do @(posedge clk); while (!in_ready);
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic rand_word();
        logic signed [23:0] s;
        logic signed [15:0] r;
        s = 24'($urandom);
        r = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
            s = $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
        if ($urandom_range(0, 3) == 0) r = 0;
        send_word(s, r);
    endtask

    initial begin
        logic [30:0] v;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed extremes under reset settings
        send_word(24'sh7FFFFF, 16'sh0000);
        send_word(-24'sd8388608, 16'sh7FFF);
        send_word(24'sh7FFFFF, -16'sd32768);
        send_word(24'sd0, 16'sd1);
        send_word(24'sd1, -16'sd1);
        send_word(-24'sd1, 16'sh4000);
        for (int i = 0; i < 6; i++) send_word(24'sh7FFFFF, 16'sh7FFF);
        drain();
        // zero gain, zero scale, max value to the unknown index
        write_reg(opi_pkg::REG_LINEAR_GAIN, 31'd0);
        write_reg(opi_pkg::REG_GYRO_SCALE, 31'd0);
        write_reg(2'd3, 31'h7FFFFFFF);
        send_word(24'sh123456, 16'sh1234);
        send_word(-24'sd8388608, -16'sd32768);
        drain();
        // max gain/scale, zero threshold: wraps heading
        write_reg(opi_pkg::REG_LINEAR_GAIN, 31'd65535);
        write_reg(opi_pkg::REG_GYRO_SCALE, 31'hFFFFFF);
        write_reg(opi_pkg::REG_RATE_THRESHOLD, 31'd0);
        for (int i = 0; i < 10; i++) send_word(24'sh7FFFFF, 16'sh7FFF);
        for (int i = 0; i < 6; i++) send_word(-24'sd8388608, -16'sd32001);
        drain();
        write_reg(opi_pkg::REG_RATE_THRESHOLD, 31'h7FFFFFFF);
        send_word(24'sh7FFFFF, 16'sh7FFF);
        drain();
        // random phases with random settings
        for (int ph = 0; ph < 6; ph++) begin
            v = 31'($urandom);
            write_reg(opi_pkg::REG_LINEAR_GAIN, v);
            v = 31'($urandom);
            write_reg(opi_pkg::REG_GYRO_SCALE, (ph == 0) ? 31'd116507 : v);
            v = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 200000));
            write_reg(opi_pkg::REG_RATE_THRESHOLD, v);
            for (int k = 0; k < 180; k++) rand_word();
            drain();
        end
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/opi_pkg.sv
sv/opi_front.sv
sv/opi_cordic_cell.sv
sv/odometry_pose_integrator.sv
tb/sv/odometry_pose_checker.sv
tb/sv/odometry_pose_integrator_tb.sv
